[sv/mrt_pkg.sv]
`default_nettype none

package mrt_pkg;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0] t_cnt;

    // request to the modular multiplier: res = (a * b) mod m, a < m
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word m;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word res;
    } t_mul_rsp;

endpackage

`default_nettype wire

[sv/mrt_mulmod.sv]
`default_nettype none

module mrt_mulmod import mrt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic  r_busy;
    t_word r_acc;
    t_word r_term;
    t_word r_b;
    t_word r_m;

    // (x + y) mod m for x, y < m, never wider than a word
    function automatic t_word add_mod(t_word x, t_word y, t_word m);
        t_word room;
        room = m - y;
        if (x >= room) begin
            return x - room;
        end
        return x + y;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // one multiplier bit per cycle: add the doubled term where the bit is set
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= '0;
            r_term <= i_req.a;
            r_b    <= i_req.b;
            r_m    <= i_req.m;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= add_mod(r_acc, r_term, r_m);
            end
            r_term <= add_mod(r_term, r_term, r_m);
            r_b    <= r_b >> 1;
        end
    end

    assign o_rsp.done = r_busy && (r_b == '0);
    assign o_rsp.res  = r_acc;

endmodule

`default_nettype wire

[sv/miller_rabin_round_tester_unit.sv]
`default_nettype none
// Sequence: a candidate below 2, equal to 2 or even goes straight to the verdict;
//   otherwise one add-shift modular product for the witness, a shift of the
//   exponent per trailing zero of p-1, then up to two products per exponent bit
//   and up to r-1 squarings.
// Throughput: one item at a time; input stall is high from acceptance until done.
// Reset: synchronous active low; clears the sequencer and output valid, re-arms the flag.

module miller_rabin_round_tester_unit import mrt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [WIDTH-1:0]  i_candidate,
    input  wire logic [WIDTH-1:0]  i_random_word,
    input  wire logic              i_last_round,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_probable_prime
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIT,
        S_SHIFT,
        S_EXP,
        S_MUL_ACC,
        S_MUL_SQ,
        S_CHK,
        S_SQ_LOOP,
        S_FIN
    } t_state;

    t_state   r_state, n_state;
    t_mul_req r_req, n_req;
    t_mul_rsp mul_rsp;
    t_word    r_p, n_p;
    t_word    r_pm1, n_pm1;
    t_word    r_e, n_e;
    t_word    r_x, n_x;
    t_word    r_sq, n_sq;
    t_cnt     r_r, n_r;
    logic     r_last, n_last;
    logic     r_ok, n_ok;
    logic     r_still, n_still;
    logic     r_out_valid, n_out_valid;
    logic     r_out_pp, n_out_pp;
    t_word    e_next;

    mrt_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (mul_rsp)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_probable_prime = r_out_pp;
    assign e_next           = r_e >> 1;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_p         = r_p;
        n_pm1       = r_pm1;
        n_e         = r_e;
        n_x         = r_x;
        n_sq        = r_sq;
        n_r         = r_r;
        n_last      = r_last;
        n_ok        = r_ok;
        n_still     = r_still;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pp    = r_out_pp;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_p    = i_candidate;
                    n_pm1  = i_candidate - t_word'(1);
                    n_e    = i_candidate - t_word'(1);
                    n_last = i_last_round;
                    n_r    = '0;
                    if (i_candidate[WIDTH-1:1] == '0) begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end else if (i_candidate == t_word'(2)) begin
                        n_ok    = 1'b1;
                        n_state = S_FIN;
                    end else if (!i_candidate[0]) begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        // witness = random mod (p-1) + 1, as the product 1 * random
                        n_req.start = 1'b1;
                        n_req.a     = t_word'(1);
                        n_req.b     = i_random_word;
                        n_req.m     = i_candidate - t_word'(1);
                        n_state     = S_WIT;
                    end
                end
            end
            S_WIT: begin
                if (mul_rsp.done) begin
                    n_sq    = mul_rsp.res + t_word'(1);
                    n_x     = t_word'(1);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // strip trailing zeros of p-1: e becomes d, r counts them
                if (!r_e[0]) begin
                    n_e = e_next;
                    n_r = r_r + t_cnt'(1);
                end else begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (r_e == '0) begin
                    n_state = S_CHK;
                end else if (r_e[0]) begin
                    n_req.start = 1'b1;
                    n_req.a     = r_x;
                    n_req.b     = r_sq;
                    n_req.m     = r_p;
                    n_state     = S_MUL_ACC;
                end else begin
                    // a clear bit with e nonzero always leaves higher bits
                    n_e         = e_next;
                    n_req.start = 1'b1;
                    n_req.a     = r_sq;
                    n_req.b     = r_sq;
                    n_req.m     = r_p;
                    n_state     = S_MUL_SQ;
                end
            end
            S_MUL_ACC: begin
                if (mul_rsp.done) begin
                    n_x = mul_rsp.res;
                    n_e = e_next;
                    if (e_next == '0) begin
                        n_state = S_CHK;
                    end else begin
                        n_req.start = 1'b1;
                        n_req.a     = r_sq;
                        n_req.b     = r_sq;
                        n_req.m     = r_p;
                        n_state     = S_MUL_SQ;
                    end
                end
            end
            S_MUL_SQ: begin
                if (mul_rsp.done) begin
                    n_sq    = mul_rsp.res;
                    n_state = S_EXP;
                end
            end
            S_CHK: begin
                n_r = r_r - t_cnt'(1);
                if ((r_x == t_word'(1)) || (r_x == r_pm1)) begin
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else if (r_r == t_cnt'(1)) begin
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_req.start = 1'b1;
                    n_req.a     = r_x;
                    n_req.b     = r_x;
                    n_req.m     = r_p;
                    n_state     = S_SQ_LOOP;
                end
            end
            S_SQ_LOOP: begin
                if (mul_rsp.done) begin
                    n_x = mul_rsp.res;
                    n_r = r_r - t_cnt'(1);
                    if (mul_rsp.res == r_pm1) begin
                        n_ok    = 1'b1;
                        n_state = S_FIN;
                    end else if ((mul_rsp.res == t_word'(1)) || (r_r == t_cnt'(1))) begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_req.start = 1'b1;
                        n_req.a     = mul_rsp.res;
                        n_req.b     = mul_rsp.res;
                        n_req.m     = r_p;
                    end
                end
            end
            S_FIN: begin
                if (!r_last) begin
                    n_still = r_still && r_ok;
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    // emit the verdict and re-arm the flag
                    n_out_valid = 1'b1;
                    n_out_pp    = r_still && r_ok;
                    n_still     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req.start <= 1'b0;
            r_still     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req.start <= n_req.start;
            r_still     <= n_still;
            r_out_valid <= n_out_valid;
        end
        r_req.a  <= n_req.a;
        r_req.b  <= n_req.b;
        r_req.m  <= n_req.m;
        r_p      <= n_p;
        r_pm1    <= n_pm1;
        r_e      <= n_e;
        r_x      <= n_x;
        r_sq     <= n_sq;
        r_r      <= n_r;
        r_last   <= n_last;
        r_ok     <= n_ok;
        r_out_pp <= n_out_pp;
    end

    a_no_done_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> !mul_rsp.done)
        else $error("multiplier reports done while a start is pending");

    a_res_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_rsp.done && (r_state != S_IDLE)) |-> (mul_rsp.res < r_req.m))
        else $error("modular product not below its modulus");

    a_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_e != '0))
        else $error("odd-part extraction on a zero word");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_last && (!r_out_valid || !i_out_stall))
            |=> (r_still && o_out_valid))
        else $error("verdict not emitted or flag not re-armed");

endmodule

`default_nettype wire
